[hdl/mpqa_pkg.sv]
// Package for the multilevel priority queue: constants, codes and word types.
package mpqa_pkg;

  localparam int Slots     = 64;
  localparam int SlotBits  = $clog2(Slots);
  localparam int LinkBits  = SlotBits + 1;
  localparam int TimeBits  = 32;
  localparam int Levels    = 3;
  localparam int CountBits = LinkBits;
  localparam logic [LinkBits-1:0] Nil = LinkBits'(Slots);

  localparam logic [2:0] CMD_ENQ     = 3'd0;
  localparam logic [2:0] CMD_DEQ     = 3'd1;
  localparam logic [2:0] CMD_MOVE    = 3'd2;
  localparam logic [2:0] CMD_PROMOTE = 3'd3;
  localparam logic [2:0] CMD_TIMEOUT = 3'd4;

  localparam logic [1:0] REG_PROMOTE = 2'd0;
  localparam logic [1:0] REG_TOP_TO  = 2'd1;
  localparam logic [1:0] REG_MED_TO  = 2'd2;

  typedef struct packed {
    logic [2:0]  command;
    logic [5:0]  slot;
    logic [1:0]  level;
    logic [31:0] stamp;
  } in_word_t;

  typedef struct packed {
    logic       found;
    logic [5:0] out_slot;
    logic [1:0] out_level;
    logic       acted;
    logic       queue_empty;
  } out_word_t;

  // Per-slot entry held in memory.
  typedef struct packed {
    logic [LinkBits-1:0] next;
    logic [LinkBits-1:0] prev;
    logic [1:0]          level;
    logic [TimeBits-1:0] stamp;
  } entry_t;

  localparam int EntryBits = $bits(entry_t);

endpackage

[hdl/mpqa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
module mpqa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hdl/mpqa_core.sv]
// Sequencer that walks the linked lists through the entry memory.
module mpqa_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mpqa_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mpqa_pkg::out_word_t  out_word,
  input  logic [31:0]          promote_lim,
  input  logic [31:0]          top_lim,
  input  logic [31:0]          med_lim
);
  localparam int SB = mpqa_pkg::SlotBits;
  localparam int LB = mpqa_pkg::LinkBits;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_DECIDE, S_RDP, S_WRP, S_RDN, S_WRN, S_RDT, S_WRT, S_WRS, S_OUT
  } state_t;

  state_t state_r;
  mpqa_pkg::in_word_t in_r;
  mpqa_pkg::entry_t   ent_r;
  mpqa_pkg::out_word_t res_r;
  mpqa_pkg::out_word_t out_r;
  logic [LB-1:0] head_r [mpqa_pkg::Levels];
  logic [LB-1:0] tail_r [mpqa_pkg::Levels];
  logic [mpqa_pkg::CountBits-1:0] count_r [mpqa_pkg::Levels];
  logic [mpqa_pkg::Slots-1:0] linked_r, tmo_r;
  logic empty_r, out_valid_r;
  logic [SB-1:0] s_r;           // slot being worked on
  logic [1:0]    lv_r;          // target level for the attach
  logic          do_attach_r;

  logic          we;
  logic [SB-1:0] waddr, raddr;
  mpqa_pkg::entry_t wdata, rdata;
  logic [mpqa_pkg::EntryBits-1:0] rdata_bits;

  mpqa_ram #(.WIDTH(mpqa_pkg::EntryBits), .DEPTH(mpqa_pkg::Slots)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr),
    .rdata(rdata_bits));
  assign rdata = mpqa_pkg::entry_t'(rdata_bits);

  // Decision values from the slot's entry as it arrives from memory.
  logic        le;
  logic [31:0] el;
  logic        ok_prom, ok_tmo, lv_ok;
  logic [1:0]  hi_lv;
  logic        any_lv;
  logic [SB-1:0] head_slot;

  always_comb begin
    el = in_r.stamp - rdata.stamp;
    le = in_r.stamp >= rdata.stamp;
    ok_prom = le && (el >= promote_lim);
    ok_tmo = le && !tmo_r[in_r.slot] &&
             ((rdata.level == 2'd2 && el > top_lim) ||
              (rdata.level == 2'd1 && el > med_lim));
    lv_ok = in_r.level != 2'd3;
    any_lv = 1'b1;
    hi_lv = 2'd0;
    if (count_r[2] != '0 && head_r[2] != mpqa_pkg::Nil) hi_lv = 2'd2;
    else if (count_r[1] != '0 && head_r[1] != mpqa_pkg::Nil) hi_lv = 2'd1;
    else if (count_r[0] != '0 && head_r[0] != mpqa_pkg::Nil) hi_lv = 2'd0;
    else any_lv = 1'b0;
    head_slot = hi_lv == 2'd2 ? head_r[2][SB-1:0] :
                hi_lv == 2'd1 ? head_r[1][SB-1:0] : head_r[0][SB-1:0];
  end

  always_comb begin
    we = 1'b0;
    waddr = s_r;
    wdata = ent_r;
    raddr = s_r;
    case (state_r)
      // A dequeue reads the head it is about to pop.
      S_RD:  raddr = (in_r.command == mpqa_pkg::CMD_DEQ) ? head_slot : s_r;
      S_RDP: raddr = ent_r.prev[SB-1:0];
      S_RDN: raddr = ent_r.next[SB-1:0];
      S_RDT: raddr = tail_r[lv_r][SB-1:0];
      S_WRP: begin
        we = 1'b1; waddr = ent_r.prev[SB-1:0];
        wdata = rdata; wdata.next = ent_r.next;
      end
      S_WRN: begin
        we = 1'b1; waddr = ent_r.next[SB-1:0];
        wdata = rdata; wdata.prev = ent_r.prev;
      end
      S_WRT: begin
        we = 1'b1; waddr = tail_r[lv_r][SB-1:0];
        wdata = rdata; wdata.next = {1'b0, s_r};
      end
      S_WRS: begin
        we = 1'b1;
        wdata.prev = tail_r[lv_r];
        wdata.next = mpqa_pkg::Nil;
        wdata.level = lv_r;
        wdata.stamp = (in_r.command == mpqa_pkg::CMD_ENQ) ? in_r.stamp : ent_r.stamp;
      end
      default: ;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      linked_r <= '0;
      tmo_r <= '0;
      empty_r <= 1'b1;
      do_attach_r <= 1'b0;
      for (int i = 0; i < mpqa_pkg::Levels; i++) begin
        head_r[i] <= mpqa_pkg::Nil;
        tail_r[i] <= mpqa_pkg::Nil;
        count_r[i] <= '0;
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            in_r <= in_word;
            s_r <= in_word.slot;
            res_r <= '0;
            do_attach_r <= 1'b0;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          if (in_r.command == mpqa_pkg::CMD_DEQ) begin
            s_r <= head_slot;
          end
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          ent_r <= rdata;
          case (in_r.command)
            mpqa_pkg::CMD_ENQ: begin
              if (lv_ok && !linked_r[s_r]) begin
                lv_r <= in_r.level; do_attach_r <= 1'b1;
                tmo_r[s_r] <= 1'b0; empty_r <= 1'b0;
                state_r <= S_RDT;
              end else begin
                state_r <= S_OUT;
              end
            end
            mpqa_pkg::CMD_DEQ: begin
              if (any_lv) begin
                res_r.found <= 1'b1;
                res_r.out_slot <= s_r;
                res_r.out_level <= hi_lv;
                state_r <= S_RDP;
              end else begin
                empty_r <= 1'b1;
                state_r <= S_OUT;
              end
            end
            mpqa_pkg::CMD_MOVE: begin
              if (lv_ok && linked_r[s_r]) begin
                lv_r <= in_r.level; do_attach_r <= 1'b1; state_r <= S_RDP;
              end else begin
                state_r <= S_OUT;
              end
            end
            mpqa_pkg::CMD_PROMOTE: begin
              if (linked_r[s_r] && ok_prom) begin
                lv_r <= 2'd1; do_attach_r <= 1'b1;
                res_r.acted <= 1'b1; state_r <= S_RDP;
              end else begin
                state_r <= S_OUT;
              end
            end
            mpqa_pkg::CMD_TIMEOUT: begin
              if (linked_r[s_r] && ok_tmo) begin
                tmo_r[s_r] <= 1'b1; res_r.acted <= 1'b1;
              end
              state_r <= S_OUT;
            end
            default: state_r <= S_OUT;
          endcase
        end
        S_RDP: begin
          // Detach: unlink from neighbors, fix head, tail and count.
          linked_r[s_r] <= 1'b0;
          if (count_r[ent_r.level] != '0)
            count_r[ent_r.level] <= count_r[ent_r.level] - 1'b1;
          if (ent_r.prev == mpqa_pkg::Nil) head_r[ent_r.level] <= ent_r.next;
          if (ent_r.next == mpqa_pkg::Nil) tail_r[ent_r.level] <= ent_r.prev;
          state_r <= (ent_r.prev != mpqa_pkg::Nil) ? S_WRP : S_RDN;
        end
        S_WRP: state_r <= S_RDN;
        S_RDN: state_r <= (ent_r.next != mpqa_pkg::Nil) ? S_WRN :
                          (do_attach_r ? S_RDT : S_OUT);
        S_WRN: state_r <= do_attach_r ? S_RDT : S_OUT;
        S_RDT: state_r <= (tail_r[lv_r] != mpqa_pkg::Nil) ? S_WRT : S_WRS;
        S_WRT: state_r <= S_WRS;
        S_WRS: begin
          if (tail_r[lv_r] == mpqa_pkg::Nil) head_r[lv_r] <= {1'b0, s_r};
          tail_r[lv_r] <= {1'b0, s_r};
          count_r[lv_r] <= count_r[lv_r] + 1'b1;
          linked_r[s_r] <= 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: begin
          // The output register holds the previous word until it is taken.
          if (!out_valid_r || !out_stall) begin
            out_r <= {res_r.found, res_r.out_slot, res_r.out_level, res_r.acted, empty_r};
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (out_valid_r && !out_stall && !(state_r == S_OUT)) out_valid_r <= 1'b0;
    end
  end
endmodule

[hdl/multilevel_priority_queue_aging_unit.sv]
// Top level of the three-level priority queue with aging and its register port.
//   channel | direction | handshake
//   in_     | input     | in_valid / in_stall, word in_word
//   out_    | output    | out_valid / out_stall, word out_word
//   cfg_    | input     | APB write/read, 3 registers at 4*i
// The sequencer walks the entry memory one read or write a cycle
// (slot, prev, next and tail neighbors).
// Reset is synchronous and active low; no clearing pass is needed.
// A stalled result holds the block until it is taken.
module multilevel_priority_queue_aging_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mpqa_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output mpqa_pkg::out_word_t out_word,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [3:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  logic [31:0] promote_r, top_r, med_r;
  logic [1:0]  ridx;

  assign ridx = cfg_paddr[3:2];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      promote_r <= 32'd60;
      top_r     <= 32'd30;
      med_r     <= 32'd60;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (ridx)
        mpqa_pkg::REG_PROMOTE: promote_r <= cfg_pwdata;
        mpqa_pkg::REG_TOP_TO:  top_r     <= cfg_pwdata;
        mpqa_pkg::REG_MED_TO:  med_r     <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      mpqa_pkg::REG_PROMOTE: cfg_prdata = promote_r;
      mpqa_pkg::REG_TOP_TO:  cfg_prdata = top_r;
      mpqa_pkg::REG_MED_TO:  cfg_prdata = med_r;
      default:               cfg_prdata = '0;
    endcase
  end

  mpqa_core u_core (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .promote_lim(promote_r), .top_lim(top_r), .med_lim(med_r));

`ifndef NO_ASSERTIONS
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.found) |-> !out_word.queue_empty)
    else $error("pop reported with empty flag set");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_word)))
    else $error("stalled result word changed");
  a_acted_not_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_word.found && out_word.acted))
    else $error("pop and check both reported");
`endif
endmodule
